### hdl/tcvf_pkg.sv
package tcvf_pkg;

  localparam int LEVEL_W = 7;
  localparam int TIME_W  = 32;
  localparam int LEN_W   = 26;
  localparam int DUR_W   = 16;
  localparam int STEP_W  = 16;
  localparam int PROD_W  = LEVEL_W + LEN_W;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(99);
  localparam int unsigned        MS_PER_S  = 1000;
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(50);

  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [1:0]         chan;
    logic [LEVEL_W-1:0] level;
  } result_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

endpackage

### hdl/three_channel_volume_fade_top.sv
// Linear volume fade engine for NUM_CHANNELS channels. A start word arms a ramp (or ends it at
// once when the duration is zero); a tick word walks every channel and issues set-volume and
// stop commands on the output channel, the final word of each input marked by last. One input
// word is handled at a time and in_stall stays high until its final command is loaded into the
// output register. Per channel a tick sends nothing, ends the fade, or forms a new level with the
// bit-serial multiply and restoring divide (7 steps each, the divide after a load step) that
// form the interpolated level. A stalled output holds the engine until its command can move on.
module three_channel_volume_fade_top #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [tcvf_pkg::STEP_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [tcvf_pkg::TIME_W-1:0]  now_ms,
  input  logic [1:0]                   channel,
  input  logic [tcvf_pkg::LEVEL_W-1:0] from_level,
  input  logic [tcvf_pkg::LEVEL_W-1:0] to_level,
  input  logic [tcvf_pkg::DUR_W-1:0]   duration_s,
  input  logic                         stop_at_end,
  input  logic [tcvf_pkg::LEVEL_W-1:0] restore_level,
  input  logic [tcvf_pkg::LEVEL_W-1:0] codec_level,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         command_kind,
  output logic [1:0]                   channel_out,
  output logic [tcvf_pkg::LEVEL_W-1:0] level,
  output logic                         last
);
  import tcvf_pkg::*;

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_CHECK    = 4'd2;
  localparam logic [3:0] S_MUL      = 4'd3;
  localparam logic [3:0] S_LEVEL    = 4'd4;
  localparam logic [3:0] S_END_TO   = 4'd5;
  localparam logic [3:0] S_END_STOP = 4'd6;
  localparam logic [3:0] S_END_REST = 4'd7;
  localparam logic [3:0] S_NEXT     = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  logic [3:0]         state;
  logic [STEP_W-1:0]  step_ms;

  logic               cap_op;
  logic [TIME_W-1:0]  cap_now;
  logic [1:0]         cap_chan;
  logic [LEVEL_W-1:0] cap_from;
  logic [LEVEL_W-1:0] cap_to;
  logic [DUR_W-1:0]   cap_dur;
  logic               cap_stop;
  logic [LEVEL_W-1:0] cap_rest;
  logic [LEVEL_W-1:0] cap_codec;

  logic [NUM_CHANNELS-1:0] ramp_active;
  logic [LEVEL_W-1:0]      ramp_from       [NUM_CHANNELS];
  logic [LEVEL_W-1:0]      ramp_to         [NUM_CHANNELS];
  logic [TIME_W-1:0]       ramp_start_ms   [NUM_CHANNELS];
  logic [LEN_W-1:0]        ramp_length_ms  [NUM_CHANNELS];
  logic [TIME_W-1:0]       next_update_ms  [NUM_CHANNELS];
  logic [LEVEL_W-1:0]      last_level_sent [NUM_CHANNELS];
  logic                    stop_flag       [NUM_CHANNELS];
  logic [LEVEL_W-1:0]      restore_value   [NUM_CHANNELS];

  logic [CW-1:0]      cnt;
  logic [CW-1:0]      idx;
  logic               ch_ok;
  logic [TIME_W-1:0]  elapsed;
  logic               dir_up;
  logic [LEVEL_W-1:0] new_level;

  logic [LEVEL_W-1:0] end_to;
  logic               end_stop;
  logic [LEVEL_W-1:0] end_rest;

  result_t            pend;
  logic               pend_v;
  logic               out_free;
  logic               prod_req;
  logic               prod_ok;
  result_t            prod;

  logic               md_start;
  logic               md_done;
  logic [LEVEL_W-1:0] md_diff;
  logic [LEVEL_W-1:0] md_quot;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign prod_ok  = !pend_v || out_free;

  assign idx     = cap_op ? cnt : CW'(cap_chan);
  assign ch_ok   = ({30'b0, cap_chan} < 32'(NUM_CHANNELS));
  assign elapsed = cap_now - ramp_start_ms[idx];
  assign dir_up  = (ramp_to[idx] >= ramp_from[idx]);
  assign md_diff = dir_up ? LEVEL_W'(ramp_to[idx] - ramp_from[idx])
                          : LEVEL_W'(ramp_from[idx] - ramp_to[idx]);
  assign new_level = dir_up ? LEVEL_W'(ramp_from[idx] + md_quot)
                            : LEVEL_W'(ramp_from[idx] - md_quot);

  assign md_start = (state == S_CHECK) && ramp_active[idx]
                    && (elapsed < TIME_W'(ramp_length_ms[idx]))
                    && (cap_now >= next_update_ms[idx]);

  tcvf_muldiv u_muldiv (
    .clk     (clk),
    .rst     (rst),
    .start   (md_start),
    .diff    (md_diff),
    .elapsed (elapsed[LEN_W-1:0]),
    .length  (ramp_length_ms[idx]),
    .done    (md_done),
    .quot    (md_quot)
  );

  always_comb begin
    prod_req   = 1'b0;
    prod.kind  = KIND_SET;
    prod.chan  = 2'(idx);
    prod.level = '0;
    unique case (state)
      S_START: begin
        prod_req   = ch_ok && (cap_dur != '0) && (cap_from != cap_codec);
        prod.level = cap_from;
      end
      S_LEVEL: begin
        prod_req   = (new_level != last_level_sent[idx]);
        prod.level = new_level;
      end
      S_END_TO: begin
        prod_req   = 1'b1;
        prod.level = end_to;
      end
      S_END_STOP: begin
        prod_req  = 1'b1;
        prod.kind = KIND_STOP;
      end
      S_END_REST: begin
        prod_req   = 1'b1;
        prod.level = end_rest;
      end
      default: prod_req = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step_ms     <= STEP_RESET;
      ramp_active <= '0;
      pend_v      <= 1'b0;
      out_valid   <= 1'b0;
      cnt         <= '0;
    end else begin
      if (cfg_write) begin
        step_ms <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (prod_req && prod_ok) begin
        if (pend_v) begin
          out_valid    <= 1'b1;
          command_kind <= pend.kind;
          channel_out  <= pend.chan;
          level        <= pend.level;
          last         <= 1'b0;
        end
        pend   <= prod;
        pend_v <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cap_op    <= op;
            cap_now   <= now_ms;
            cap_chan  <= channel;
            cap_from  <= clamp_level(from_level);
            cap_to    <= clamp_level(to_level);
            cap_dur   <= duration_s;
            cap_stop  <= stop_at_end;
            cap_rest  <= clamp_level(restore_level);
            cap_codec <= codec_level;
            cnt       <= '0;
            state     <= op ? S_CHECK : S_START;
          end
        end
        S_START: begin
          if (!ch_ok) begin
            state <= S_FINISH;
          end else if (cap_dur == '0) begin
            ramp_active[idx] <= 1'b0;
            end_to   <= cap_to;
            end_stop <= cap_stop;
            end_rest <= cap_rest;
            state    <= S_END_TO;
          end else begin
            ramp_active[idx]     <= 1'b1;
            ramp_from[idx]       <= cap_from;
            ramp_to[idx]         <= cap_to;
            ramp_start_ms[idx]   <= cap_now;
            ramp_length_ms[idx]  <= LEN_W'(cap_dur * MS_PER_S);
            next_update_ms[idx]  <= '0;
            last_level_sent[idx] <= cap_from;
            stop_flag[idx]       <= cap_stop;
            restore_value[idx]   <= cap_rest;
            state                <= S_FINISH;
          end
        end
        S_CHECK: begin
          if (!ramp_active[idx]) begin
            state <= S_NEXT;
          end else if (elapsed >= TIME_W'(ramp_length_ms[idx])) begin
            ramp_active[idx] <= 1'b0;
            end_to   <= ramp_to[idx];
            end_stop <= stop_flag[idx];
            end_rest <= restore_value[idx];
            state    <= S_END_TO;
          end else if (cap_now < next_update_ms[idx]) begin
            state <= S_NEXT;
          end else begin
            next_update_ms[idx] <= cap_now + TIME_W'(step_ms);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (md_done) begin
            state <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          if (!prod_req) begin
            state <= S_NEXT;
          end else if (prod_ok) begin
            last_level_sent[idx] <= new_level;
            state <= S_NEXT;
          end
        end
        S_END_TO: begin
          if (prod_ok) begin
            state <= end_stop ? S_END_STOP : (cap_op ? S_NEXT : S_FINISH);
          end
        end
        S_END_STOP: begin
          if (prod_ok) begin
            state <= S_END_REST;
          end
        end
        S_END_REST: begin
          if (prod_ok) begin
            state <= cap_op ? S_NEXT : S_FINISH;
          end
        end
        S_NEXT: begin
          if (cnt == CW'(NUM_CHANNELS - 1)) begin
            state <= S_FINISH;
          end else begin
            cnt   <= cnt + CW'(1);
            state <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (!pend_v) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid    <= 1'b1;
            command_kind <= pend.kind;
            channel_out  <= pend.chan;
            level        <= pend.level;
            last         <= 1'b1;
            pend_v       <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/tcvf_muldiv.sv
module tcvf_muldiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tcvf_pkg::LEVEL_W-1:0] diff,
  input  logic [tcvf_pkg::LEN_W-1:0]   elapsed,
  input  logic [tcvf_pkg::LEN_W-1:0]   length,
  output logic                         done,
  output logic [tcvf_pkg::LEVEL_W-1:0] quot
);
  import tcvf_pkg::*;

  localparam int CNT_W = $clog2(LEVEL_W);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;

  logic [1:0]         phase;
  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  acc;
  logic [PROD_W-1:0]  mc;
  logic [LEVEL_W-1:0] dsr;
  logic [LEN_W-1:0]   dvs;
  logic [LEN_W-1:0]   rem;
  logic [LEVEL_W-1:0] plo;
  logic [LEN_W:0]     trial;

  assign trial = {rem, plo[LEVEL_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            acc   <= '0;
            mc    <= PROD_W'(elapsed);
            dsr   <= diff;
            dvs   <= length;
            cnt   <= '0;
            phase <= P_MUL;
          end
        end
        P_MUL: begin
          if (dsr[0]) begin
            acc <= acc + mc;
          end
          mc  <= mc << 1;
          dsr <= dsr >> 1;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(LEVEL_W - 1)) begin
            cnt   <= '0;
            phase <= P_DIV;
          end
        end
        P_DIV: begin
          if (cnt == '0) begin
            rem  <= acc[PROD_W-1:LEVEL_W];
            plo  <= acc[LEVEL_W-1:0];
            quot <= '0;
            cnt  <= cnt + CNT_W'(1);
          end else begin
            if (trial >= {1'b0, dvs}) begin
              rem  <= LEN_W'(trial - {1'b0, dvs});
              quot <= {quot[LEVEL_W-2:0], 1'b1};
            end else begin
              rem  <= trial[LEN_W-1:0];
              quot <= {quot[LEVEL_W-2:0], 1'b0};
            end
            plo <= plo << 1;
            cnt <= cnt + CNT_W'(1);
            if (cnt == CNT_W'(LEVEL_W)) begin
              done  <= 1'b1;
              phase <= P_IDLE;
            end
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcvf_pkg::*;

  localparam int NCH            = 3;
  localparam logic OP_START     = 1'b0;
  localparam logic OP_TICK      = 1'b1;
  localparam int MAX_WAIT       = 12;
  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_WORDS    = 72;

  typedef struct packed {
    logic               op;
    logic [TIME_W-1:0]  now;
    logic [1:0]         chan;
    logic [LEVEL_W-1:0] from_lv;
    logic [LEVEL_W-1:0] to_lv;
    logic [DUR_W-1:0]   dur;
    logic               stop;
    logic [LEVEL_W-1:0] restore;
    logic [LEVEL_W-1:0] codec;
  } fade_word_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         chan;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } fade_cmd_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [STEP_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                op = 1'b0;
  logic [TIME_W-1:0]   now_ms = '0;
  logic [1:0]          channel = '0;
  logic [LEVEL_W-1:0]  from_level = '0;
  logic [LEVEL_W-1:0]  to_level = '0;
  logic [DUR_W-1:0]    duration_s = '0;
  logic                stop_at_end = 1'b0;
  logic [LEVEL_W-1:0]  restore_level = '0;
  logic [LEVEL_W-1:0]  codec_level = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                command_kind;
  logic [1:0]          channel_out;
  logic [LEVEL_W-1:0]  level;
  logic                last;

  logic [STEP_W-1:0]   step_reg;
  logic                ch_active [NCH];
  logic [LEVEL_W-1:0]  ch_from [NCH];
  logic [LEVEL_W-1:0]  ch_to [NCH];
  logic [LEVEL_W-1:0]  ch_sent [NCH];
  logic [LEVEL_W-1:0]  ch_restore [NCH];
  logic [TIME_W-1:0]   ch_start [NCH];
  logic [TIME_W-1:0]   ch_next [NCH];
  logic [31:0]         ch_len [NCH];
  logic                ch_stop [NCH];

  fade_cmd_t           cmd_queue [$];
  fade_cmd_t           new_cmds [$];
  logic [TIME_W-1:0]   sim_ms = '0;
  bit                  in_burst = 1'b0;
  bit                  out_burst = 1'b0;
  int                  errors = 0;

  always #10 clk = ~clk;

  three_channel_volume_fade_top #(
    .NUM_CHANNELS(NCH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .now_ms(now_ms),
    .channel(channel),
    .from_level(from_level),
    .to_level(to_level),
    .duration_s(duration_s),
    .stop_at_end(stop_at_end),
    .restore_level(restore_level),
    .codec_level(codec_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .command_kind(command_kind),
    .channel_out(channel_out),
    .level(level),
    .last(last)
  );

  function automatic logic [LEVEL_W-1:0] sat99(input logic [LEVEL_W-1:0] v);
    return (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic void add_cmd(input logic kind, input logic [1:0] chan,
                                  input logic [LEVEL_W-1:0] lv);
    fade_cmd_t c;
    c.kind  = kind;
    c.chan  = chan;
    c.level = (kind == KIND_STOP) ? '0 : lv;
    c.last  = 1'b0;
    new_cmds.push_back(c);
  endfunction

  function automatic void add_fade_end(input logic [1:0] chan, input logic [LEVEL_W-1:0] to_lv,
                                       input logic stop, input logic [LEVEL_W-1:0] restore);
    add_cmd(KIND_SET, chan, to_lv);
    if (stop) begin
      add_cmd(KIND_STOP, chan, '0);
      add_cmd(KIND_SET, chan, restore);
    end
  endfunction

  function automatic void predict_start(input fade_word_t w);
    logic [LEVEL_W-1:0] from_c;
    logic [LEVEL_W-1:0] to_c;
    logic [LEVEL_W-1:0] rest_c;
    int ch;
    ch = int'(w.chan);
    if (ch >= NCH) return;
    from_c = sat99(w.from_lv);
    to_c   = sat99(w.to_lv);
    rest_c = sat99(w.restore);
    ch_active[ch] = 1'b0;
    if (w.dur == '0) begin
      add_fade_end(w.chan, to_c, w.stop, rest_c);
      return;
    end
    if (from_c != w.codec) add_cmd(KIND_SET, w.chan, from_c);
    ch_from[ch]    = from_c;
    ch_to[ch]      = to_c;
    ch_start[ch]   = w.now;
    ch_len[ch]     = 32'(w.dur) * MS_PER_S;
    ch_next[ch]    = '0;
    ch_sent[ch]    = from_c;
    ch_stop[ch]    = w.stop;
    ch_restore[ch] = rest_c;
    ch_active[ch]  = 1'b1;
  endfunction

  function automatic void predict_tick(input fade_word_t w);
    logic [31:0]        elapsed;
    logic [63:0]        mag;
    logic [LEVEL_W-1:0] span;
    logic [LEVEL_W-1:0] lv;
    for (int ch = 0; ch < NCH; ch++) begin
      if (!ch_active[ch]) continue;
      elapsed = w.now - ch_start[ch];
      if (elapsed >= ch_len[ch]) begin
        add_fade_end(2'(ch), ch_to[ch], ch_stop[ch], ch_restore[ch]);
        ch_active[ch] = 1'b0;
        continue;
      end
      if (w.now < ch_next[ch]) continue;
      ch_next[ch] = w.now + 32'(step_reg);
      if (ch_to[ch] >= ch_from[ch]) begin
        span = ch_to[ch] - ch_from[ch];
        mag  = 64'(span) * 64'(elapsed) / 64'(ch_len[ch]);
        lv   = ch_from[ch] + LEVEL_W'(mag);
      end else begin
        span = ch_from[ch] - ch_to[ch];
        mag  = 64'(span) * 64'(elapsed) / 64'(ch_len[ch]);
        lv   = ch_from[ch] - LEVEL_W'(mag);
      end
      if (lv > LEVEL_MAX) lv = LEVEL_MAX;
      if (lv != ch_sent[ch]) begin
        add_cmd(KIND_SET, 2'(ch), lv);
        ch_sent[ch] = lv;
      end
    end
  endfunction

  function automatic void predict_word(input fade_word_t w);
    new_cmds.delete();
    if (w.op == OP_START) predict_start(w);
    else predict_tick(w);
    if (new_cmds.size() > 0) new_cmds[new_cmds.size()-1].last = 1'b1;
    foreach (new_cmds[i]) cmd_queue.push_back(new_cmds[i]);
  endfunction

  function automatic fade_word_t start_word(input int ch, input int from_lv, input int to_lv,
                                            input int dur, input bit stop, input int restore,
                                            input int codec);
    fade_word_t w;
    w.op      = OP_START;
    w.now     = sim_ms;
    w.chan    = 2'(ch);
    w.from_lv = LEVEL_W'(from_lv);
    w.to_lv   = LEVEL_W'(to_lv);
    w.dur     = DUR_W'(dur);
    w.stop    = stop;
    w.restore = LEVEL_W'(restore);
    w.codec   = LEVEL_W'(codec);
    return w;
  endfunction

  function automatic fade_word_t tick_word(input logic [TIME_W-1:0] t);
    fade_word_t w;
    sim_ms = t;
    w = '0;
    w.op  = OP_TICK;
    w.now = t;
    return w;
  endfunction

  function automatic fade_word_t random_word();
    fade_word_t w;
    w.chan    = 2'($urandom);
    w.from_lv = LEVEL_W'($urandom);
    w.to_lv   = LEVEL_W'($urandom);
    w.dur     = DUR_W'($urandom);
    w.stop    = 1'($urandom);
    w.restore = LEVEL_W'($urandom);
    w.codec   = LEVEL_W'($urandom);
    if ($urandom_range(0, 99) < 18) begin
      w.op      = OP_START;
      w.chan    = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, NCH-1));
      if ($urandom_range(0, 4) != 0) w.from_lv = LEVEL_W'($urandom_range(0, 99));
      if ($urandom_range(0, 4) != 0) w.to_lv = LEVEL_W'($urandom_range(0, 99));
      case ($urandom_range(0, 19))
        0, 1:    w.dur = '0;
        2, 3, 4: w.dur = DUR_W'($urandom_range(5, 300));
        5:       w.dur = DUR_W'($urandom);
        default: w.dur = DUR_W'($urandom_range(1, 3));
      endcase
      if ($urandom_range(0, 3) != 0) w.restore = LEVEL_W'($urandom_range(0, 99));
      if ($urandom_range(0, 1) != 0) w.codec = sat99(w.from_lv);
    end else begin
      w.op = OP_TICK;
      case ($urandom_range(0, 39))
        0:       sim_ms = $urandom;
        1, 2, 3: sim_ms = sim_ms + $urandom_range(0, 6000);
        default: sim_ms = sim_ms + $urandom_range(0, 400);
      endcase
    end
    w.now = sim_ms;
    return w;
  endfunction

  task automatic send_word(input fade_word_t w);
    int gap;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    op            <= w.op;
    now_ms        <= w.now;
    channel       <= w.chan;
    from_level    <= w.from_lv;
    to_level      <= w.to_lv;
    duration_s    <= w.dur;
    stop_at_end   <= w.stop;
    restore_level <= w.restore;
    codec_level   <= w.codec;
    do @(posedge clk); while (in_stall);
    predict_word(w);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    step_reg = v;
    cfg_write <= 1'b0;
  endtask

  task automatic test_instant_fades();
    sim_ms = '0;
    send_word(start_word(0, 127, 127, 0, 1'b0, 127, 127));
    send_word(start_word(1, 0, 0, 0, 1'b1, 127, 0));
    send_word(start_word(2, 55, 42, 0, 1'b1, 5, 99));
    send_word(start_word(3, 10, 20, 0, 1'b1, 30, 0));
    send_word(start_word(3, 10, 20, 5, 1'b0, 30, 0));
    send_word(tick_word(32'd0));
  endtask

  task automatic test_ramp_steps();
    sim_ms = 32'd1000;
    send_word(start_word(0, 127, 0, 2, 1'b1, 30, 99));
    send_word(start_word(1, 10, 90, 1, 1'b0, 0, 120));
    send_word(start_word(2, 0, 99, 65535, 1'b0, 0, 0));
    send_word(tick_word(32'd1500));
    send_word(tick_word(32'd1520));
    send_word(tick_word(32'd2000));
    send_word(start_word(0, 20, 60, 1, 1'b1, 0, 50));
    send_word(tick_word(32'd3000));
    send_word(tick_word(32'd65535999));
    send_word(tick_word(32'd65536000));
  endtask

  task automatic test_wrap_and_zero_step();
    drain_outputs();
    write_step('0);
    sim_ms = 32'hFFFF_FC00;
    send_word(start_word(0, 0, 99, 3, 1'b0, 0, 5));
    send_word(start_word(1, 99, 0, 1, 1'b1, 50, 99));
    send_word(tick_word(32'hFFFF_FE00));
    send_word(tick_word(32'hFFFF_FE01));
    send_word(tick_word(32'h0000_0100));
    send_word(tick_word(32'h0000_0800));
  endtask

  task automatic test_random_fades();
    logic [STEP_W-1:0] step_val;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       step_val = STEP_RESET;
        1:       step_val = '0;
        2:       step_val = STEP_W'(1);
        3:       step_val = '1;
        4:       step_val = STEP_W'($urandom_range(2, 200));
        default: step_val = STEP_W'($urandom);
      endcase
      drain_outputs();
      write_step(step_val);
      sim_ms = $urandom;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 24 == 0) begin
          in_burst  = ($urandom_range(0, 3) == 0);
          out_burst = ($urandom_range(0, 3) == 0);
        end
        send_word(random_word());
      end
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  initial begin : result_checker
    int        hold;
    fade_cmd_t want;
    while (rst) @(posedge clk);
    forever begin
      hold = draw_wait(out_burst);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      if (cmd_queue.size() == 0) begin
        $error("unexpected command: kind %0d channel %0d level %0d last %0d",
               command_kind, channel_out, level, last);
        errors++;
      end else begin
        want = cmd_queue.pop_front();
        if (command_kind !== want.kind) begin
          $error("command_kind: expected %0d, got %0d", want.kind, command_kind);
          errors++;
        end
        if (channel_out !== want.chan) begin
          $error("channel_out: expected %0d, got %0d", want.chan, channel_out);
          errors++;
        end
        if (level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, level);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    step_reg = STEP_RESET;
    foreach (ch_active[i]) ch_active[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_instant_fades();
    test_ramp_steps();
    test_wrap_and_zero_step();
    test_random_fades();
    drain_outputs();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
